// File: src/pqc_psk_handshake_controller_defines.svh
// Assertion macros shared by the handshake controller RTL.
`ifndef PQC_PSK_HANDSHAKE_CONTROLLER_DEFINES_SVH
`define PQC_PSK_HANDSHAKE_CONTROLLER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PHC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define PHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/phc_pkg.sv
// Package: widths, codes and shared types of the handshake controller.
`default_nettype none
package phc_pkg;

  localparam int unsigned TimeWidth = 64;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 32;

  typedef logic [TimeWidth-1:0] time_t;

  localparam logic [2:0] OpPoll = 3'd0;
  localparam logic [2:0] OpM1a  = 3'd1;
  localparam logic [2:0] OpM1b  = 3'd2;
  localparam logic [2:0] OpM2a  = 3'd3;
  localparam logic [2:0] OpM2b  = 3'd4;

  localparam logic [2:0] ActNone     = 3'd0;
  localparam logic [2:0] ActStartM1  = 3'd1;
  localparam logic [2:0] ActResendM1 = 3'd2;
  localparam logic [2:0] ActAcceptM1 = 3'd3;
  localparam logic [2:0] ActSendM2   = 3'd4;
  localparam logic [2:0] ActAcceptM2 = 3'd5;
  localparam logic [2:0] ActFinish   = 3'd6;
  localparam logic [2:0] ActGiveUp   = 3'd7;

  localparam logic [1:0] StIdle    = 2'd0;
  localparam logic [1:0] StWaitM2a = 2'd1;
  localparam logic [1:0] StWaitM2b = 2'd2;
  localparam logic [1:0] StWaitM1b = 2'd3;

  localparam logic [1:0] RoleInitiator = 2'd1;
  localparam logic [1:0] RoleResponder = 2'd2;

  localparam logic [CfgIdxWidth-1:0] CfgRole     = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgInterval = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgRetries  = 2'd2;

  localparam logic [31:0] IntervalReset = 32'd3600;
  localparam logic [3:0]  RetriesReset  = 4'd5;

  typedef struct packed {
    logic [1:0]  role;
    logic [31:0] interval;
    logic [3:0]  max_retries;
  } cfg_t;

  typedef struct packed {
    logic [1:0] pstate;
    logic [3:0] retry;
    time_t      last_init;
    time_t      last_hs;
  } hs_state_t;

  typedef struct packed {
    logic [2:0] op;
    logic       length_ok;
    logic       mac_ok;
    time_t      msg_time;
    time_t      now;
  } event_t;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] proto_state;
    logic [3:0] retry_count_out;
  } result_t;

endpackage
`default_nettype wire

// File: src/phc_if.sv
// Channel interfaces: event words in, result words out.
`default_nettype none
interface phc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic        length_ok;
  logic        mac_ok;
  logic [63:0] msg_time;
  logic [63:0] now;

  modport source (output valid, op, length_ok, mac_ok, msg_time, now, input ready);
  modport sink (input valid, op, length_ok, mac_ok, msg_time, now, output ready);
endinterface

interface phc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [1:0] proto_state;
  logic [3:0] retry_count_out;

  modport source (output valid, action, proto_state, retry_count_out, input ready);
  modport sink (input valid, action, proto_state, retry_count_out, output ready);
endinterface
`default_nettype wire

// File: src/phc_cfg_regs.sv
// Configuration registers written through the plain write port.
`default_nettype none
module phc_cfg_regs (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire logic [phc_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [phc_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  output phc_pkg::cfg_t                       cfg_o
);
  import phc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgRole:     cfg_d.role = cfg_wdata_i[1:0];
        CfgInterval: cfg_d.interval = cfg_wdata_i[31:0];
        CfgRetries:  cfg_d.max_retries = cfg_wdata_i[3:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.role        <= 2'd0;
      cfg_q.interval    <= IntervalReset;
      cfg_q.max_retries <= RetriesReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule
`default_nettype wire

// File: src/phc_step.sv
// Next-state and action logic for one event.
`default_nettype none
module phc_step (
  input  wire phc_pkg::cfg_t      cfg_i,
  input  wire phc_pkg::hs_state_t cur_i,
  input  wire phc_pkg::event_t    ev_i,
  output phc_pkg::hs_state_t      nxt_o,
  output logic [2:0]              action_o
);
  import phc_pkg::*;

  logic       msg_ok;
  logic       is_init;
  logic       is_resp;
  time_t      elapsed;
  logic       due;
  logic [4:0] tick;
  logic       give_up;

  assign msg_ok  = ev_i.length_ok & ev_i.mac_ok;
  assign is_init = (cfg_i.role == RoleInitiator);
  assign is_resp = (cfg_i.role == RoleResponder);
  assign elapsed = ev_i.now - cur_i.last_hs;
  assign due     = (cur_i.last_hs == '0) || (elapsed > TimeWidth'(cfg_i.interval));
  assign tick    = {1'b0, cur_i.retry} + 5'd1;
  assign give_up = tick > {1'b0, cfg_i.max_retries};

  always_comb begin
    nxt_o    = cur_i;
    action_o = ActNone;
    case (ev_i.op)
      OpPoll: begin
        if (cur_i.pstate == StIdle) begin
          if (is_init && due) begin
            nxt_o.pstate = StWaitM2a;
            nxt_o.retry  = 4'd0;
            action_o     = ActStartM1;
          end
        end else if (give_up) begin
          nxt_o.pstate = StIdle;
          nxt_o.retry  = 4'd0;
          action_o     = ActGiveUp;
        end else begin
          nxt_o.retry = tick[3:0];
          action_o    = (cur_i.pstate == StWaitM1b) ? ActNone : ActResendM1;
        end
      end
      OpM1a: begin
        if (is_resp && msg_ok && (ev_i.msg_time > cur_i.last_init)) begin
          nxt_o.last_init = ev_i.msg_time;
          nxt_o.pstate    = StWaitM1b;
          action_o        = ActAcceptM1;
        end
      end
      OpM1b: begin
        if (is_resp && msg_ok && (cur_i.pstate == StWaitM1b)) begin
          nxt_o.pstate  = StIdle;
          nxt_o.retry   = 4'd0;
          nxt_o.last_hs = ev_i.now;
          action_o      = ActSendM2;
        end
      end
      OpM2a: begin
        if (is_init && msg_ok && (cur_i.pstate == StWaitM2a)) begin
          nxt_o.pstate = StWaitM2b;
          nxt_o.retry  = 4'd0;
          action_o     = ActAcceptM2;
        end
      end
      OpM2b: begin
        if (is_init && msg_ok && (cur_i.pstate == StWaitM2b)) begin
          nxt_o.pstate  = StIdle;
          nxt_o.retry   = 4'd0;
          nxt_o.last_hs = ev_i.now;
          action_o      = ActFinish;
        end
      end
      default: action_o = ActNone;
    endcase
  end
endmodule
`default_nettype wire

// File: src/pqc_psk_handshake_controller.sv
// Top level: four-message PSK handshake controller with registered event and result words.
//
// Usage:
//   in_i   carries one event per word: a poll tick with the current time,
//          or an M1A/M1B/M2A/M2B arrival with length and MAC verdicts (and the
//          M1A timestamp). Every event word yields exactly one result word.
//   out_o  carries the action code, the protocol state after the event and
//          the retry count after the event.
//   cfg_*  writes role, handshake interval, retry limit: user writes when idle, unchecked.
// Timing: an event word is captured in the input register, evaluated by the
//   step logic and written to the result register once that register is empty
//   or being read. One word per cycle is sustained while out_o.ready is high.
// Reset: state idle, retry count zero, both timestamps zero, registers at
//   role none, interval 3600, retry limit 5; no words in flight.
// Stall: while out_o.ready is low the result holds; one more event word is
//   still taken into the input register, then in_i.ready drops.
`default_nettype none
`include "pqc_psk_handshake_controller_defines.svh"
module pqc_psk_handshake_controller (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  phc_in_if.sink                                in_i,
  phc_out_if.source                             out_o,
  input  wire                                   cfg_we_i,
  input  wire logic [phc_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [phc_pkg::CfgDataWidth-1:0] cfg_wdata_i
);
  import phc_pkg::*;

  cfg_t      cfg;
  event_t    ev_q, ev_d;
  logic      ev_valid_q, ev_valid_d;
  hs_state_t st_q, st_d, st_step;
  logic [2:0] step_action;
  result_t   res_q, res_d;
  logic      res_valid_q, res_valid_d;
  logic      advance;
  logic      take;

  phc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  phc_step u_step (
    .cfg_i    (cfg),
    .cur_i    (st_q),
    .ev_i     (ev_q),
    .nxt_o    (st_step),
    .action_o (step_action)
  );

  assign advance     = ev_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready  = !ev_valid_q || advance;
  assign take        = in_i.valid && in_i.ready;

  assign ev_valid_d  = take || (ev_valid_q && !advance);
  assign res_valid_d = advance || (res_valid_q && !out_o.ready);
  assign st_d        = advance ? st_step : st_q;

  always_comb begin
    ev_d = ev_q;
    if (take) begin
      ev_d.op        = in_i.op;
      ev_d.length_ok = in_i.length_ok;
      ev_d.mac_ok    = in_i.mac_ok;
      ev_d.msg_time  = in_i.msg_time[TimeWidth-1:0];
      ev_d.now       = in_i.now[TimeWidth-1:0];
    end
  end

  always_comb begin
    res_d = res_q;
    if (advance) begin
      res_d.action          = step_action;
      res_d.proto_state     = st_step.pstate;
      res_d.retry_count_out = st_step.retry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      ev_valid_q  <= ev_valid_d;
      res_valid_q <= res_valid_d;
      st_q        <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q  <= ev_d;
    res_q <= res_d;
  end

  assign out_o.valid           = res_valid_q;
  assign out_o.action          = res_q.action;
  assign out_o.proto_state     = res_q.proto_state;
  assign out_o.retry_count_out = res_q.retry_count_out;

  `PHC_ASSERT_IMP(a_idle_no_retry, clk_i, rst_ni, st_q.pstate == StIdle, st_q.retry == 4'd0)
  `PHC_ASSERT_NEXT(a_advance_fills, clk_i, rst_ni, advance, res_valid_q)
  `PHC_ASSERT_NEXT(a_state_match, clk_i, rst_ni, advance, res_q.proto_state == st_q.pstate)
  `PHC_ASSERT_IMP(a_giveup_idle, clk_i, rst_ni,
                  res_valid_q && res_q.action == ActGiveUp,
                  res_q.proto_state == StIdle && res_q.retry_count_out == 4'd0)
endmodule
`default_nettype wire
